// File: rtl/core/generation_handle_slot_pool_unit_macros.svh
// Assertion macros for the generation handle slot pool.
// Included by the files that check their own behaviour; depends on nothing else.
`ifndef GENERATION_HANDLE_SLOT_POOL_UNIT_MACROS_SVH
`define GENERATION_HANDLE_SLOT_POOL_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GHSP_ASSERT_SAME(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
`define GHSP_ASSERT_NEXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define GHSP_ASSERT_SAME(lbl, ck, rn, pre, post)
`define GHSP_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

// File: rtl/core/ghsp_pkg.sv
// Shared constants, types and codes of the generation handle slot pool.
// Used by the free slot finder and the top module; depends on nothing.
package ghsp_pkg;

    localparam int POOL_SIZE   = 64;
    localparam int INDEX_BITS  = 6;
    localparam int GEN_BITS    = 25;
    localparam int PIN_BITS    = 16;
    localparam int HANDLE_BITS = 32;
    localparam logic [GEN_BITS:0] GENERATION_MAX = 26'h1ff_ffff;

    localparam int GROUP_SIZE = 8;
    localparam int LOCAL_BITS = 3;
    localparam int GROUPS     = (POOL_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_PIN   = 2'd1,
        CMD_UNPIN = 2'd2,
        CMD_FREE  = 2'd3
    } ghsp_cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_STALE     = 3'd2,
        ST_BUSY      = 3'd3,
        ST_WAITERS   = 3'd4,
        ST_FULL      = 3'd5
    } ghsp_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RMW  = 1'b1
    } ghsp_state_t;

    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [PIN_BITS-1:0] pins;
    } ghsp_entry_t;

    // Occupancy map update from the controller to the free slot finder.
    typedef struct packed {
        logic                  set;
        logic                  clr;
        logic [INDEX_BITS-1:0] idx;
    } ghsp_map_upd_t;

endpackage

// File: rtl/core/ghsp_ram.sv
// Synchronous RAM with one read port, one write port and a registered read.
// Generic; depends on nothing.
module ghsp_ram #(
    parameter int DEPTH     = 64,
    parameter int WIDTH     = 41,
    parameter int ADDR_BITS = 6
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/ghsp_free_finder.sv
// Occupancy map of the slot pool and a two-level search for the lowest free slot.
// Depends on ghsp_pkg.
module ghsp_free_finder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ghsp_pkg::ghsp_map_upd_t         upd,
    output logic [ghsp_pkg::POOL_SIZE-1:0]  in_use,
    output logic                            any_free,
    output logic [ghsp_pkg::INDEX_BITS-1:0] free_idx
);

    logic [ghsp_pkg::POOL_SIZE-1:0]  in_use_reg;
    logic [ghsp_pkg::POOL_SIZE-1:0]  in_use_next;
    logic [ghsp_pkg::GROUPS-1:0]     grp_any_reg;
    logic [ghsp_pkg::GROUPS-1:0]     grp_any_next;
    logic [ghsp_pkg::LOCAL_BITS-1:0] grp_idx_reg  [ghsp_pkg::GROUPS];
    logic [ghsp_pkg::LOCAL_BITS-1:0] grp_idx_next [ghsp_pkg::GROUPS];

    always_comb
    begin
        in_use_next = in_use_reg;
        if (upd.set)
        begin
            in_use_next[upd.idx] = 1'b1;
        end
        else if (upd.clr)
        begin
            in_use_next[upd.idx] = 1'b0;
        end
    end

    // The first level works on the map as it will be after this cycle, so the
    // registered group summaries always describe the current map.
    always_comb
    begin
        for (int g = 0; g < ghsp_pkg::GROUPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int j = ghsp_pkg::GROUP_SIZE - 1; j >= 0; j--)
            begin
                if ((g * ghsp_pkg::GROUP_SIZE + j) < ghsp_pkg::POOL_SIZE)
                begin
                    if (!in_use_next[g * ghsp_pkg::GROUP_SIZE + j])
                    begin
                        grp_any_next[g] = 1'b1;
                        grp_idx_next[g] = ghsp_pkg::LOCAL_BITS'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            grp_any_reg <= '1;
            for (int g = 0; g < ghsp_pkg::GROUPS; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
        end
        else
        begin
            in_use_reg  <= in_use_next;
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < ghsp_pkg::GROUPS; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int g = ghsp_pkg::GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                any_free = 1'b1;
                free_idx = ghsp_pkg::INDEX_BITS'(g * ghsp_pkg::GROUP_SIZE
                                                 + int'(grp_idx_reg[g]));
            end
        end
    end

    assign in_use = in_use_reg;

endmodule

// File: rtl/core/generation_handle_slot_pool_unit.sv
// Generation handle slot pool: alloc, pin, unpin and free on 64 slots whose generation
// and pin count live in one synchronous RAM. The idle state reads the slot's entry from
// the RAM; the read-modify-write state checks it, writes it back and loads the result
// register; the next item is taken once the block is back in idle. A result held by
// out_stall keeps the read-modify-write state waiting. No clearing pass follows reset: a
// per-slot written flag makes untouched entries read as zero, so items are taken right after reset.
`include "generation_handle_slot_pool_unit_macros.svh"

module generation_handle_slot_pool_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] handle,
    input  logic        waiters_empty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] handle_out
);

    localparam int EntryBits = $bits(ghsp_pkg::ghsp_entry_t);

    ghsp_pkg::ghsp_state_t             state_reg;
    ghsp_pkg::ghsp_state_t             state_next;
    logic                              in_accept;
    logic                              go;

    ghsp_pkg::ghsp_cmd_t               cmd_reg;
    logic [31:0]                       handle_reg;
    logic                              empty_reg;
    logic [ghsp_pkg::INDEX_BITS-1:0]   idx_reg;
    logic                              full_reg;
    logic                              rd_written_reg;
    logic [ghsp_pkg::POOL_SIZE-1:0]    written_reg;

    logic [ghsp_pkg::INDEX_BITS-1:0]   rd_addr;
    logic [EntryBits-1:0]              ram_rdata;
    ghsp_pkg::ghsp_entry_t             entry_old;
    ghsp_pkg::ghsp_entry_t             entry_new;
    logic                              wr_en;

    logic [ghsp_pkg::POOL_SIZE-1:0]    in_use;
    logic                              any_free;
    logic [ghsp_pkg::INDEX_BITS-1:0]   free_idx;
    ghsp_pkg::ghsp_map_upd_t           map_upd;

    logic                              h_neg;
    logic                              idx_ok;
    logic [ghsp_pkg::GEN_BITS-1:0]     h_gen;
    logic                              malformed;
    logic                              live;
    logic [ghsp_pkg::GEN_BITS:0]       gen_sum;
    logic [ghsp_pkg::GEN_BITS-1:0]     gen_bumped;

    ghsp_pkg::ghsp_status_t            status_calc;
    logic [31:0]                       hout_calc;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    ghsp_pkg::ghsp_status_t            status_reg;
    logic [31:0]                       handle_out_reg;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ghsp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ghsp_pkg::S_RMW;
                end
            end
            ghsp_pkg::S_RMW:
            begin
                if (go)
                begin
                    state_next = ghsp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ghsp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ghsp_pkg::S_IDLE);
        go       = (state_reg == ghsp_pkg::S_RMW) && !(out_valid_reg && out_stall);
    end

    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghsp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // --------------------------------------------------------------- read side
    // An alloc reads the entry of the lowest free slot, every other command the
    // entry its handle names.
    assign rd_addr = (ghsp_pkg::ghsp_cmd_t'(command) == ghsp_pkg::CMD_ALLOC)
                     ? free_idx : handle[ghsp_pkg::INDEX_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= ghsp_pkg::ghsp_cmd_t'(command);
            handle_reg <= handle;
            empty_reg  <= waiters_empty;
            idx_reg    <= rd_addr;
            full_reg   <= !any_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
            if (wr_en)
            begin
                written_reg[idx_reg] <= 1'b1;
            end
        end
    end

    ghsp_ram #(
        .DEPTH     (ghsp_pkg::POOL_SIZE),
        .WIDTH     (EntryBits),
        .ADDR_BITS (ghsp_pkg::INDEX_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (entry_new)
    );

    ghsp_free_finder u_free_finder (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (map_upd),
        .in_use   (in_use),
        .any_free (any_free),
        .free_idx (free_idx)
    );

    // ------------------------------------------------------- modify and write
    assign entry_old = rd_written_reg ? ghsp_pkg::ghsp_entry_t'(ram_rdata)
                                      : ghsp_pkg::ghsp_entry_t'('0);

    assign h_neg     = handle_reg[31];
    assign idx_ok    = ({1'b0, handle_reg[ghsp_pkg::INDEX_BITS-1:0]}
                        < (ghsp_pkg::INDEX_BITS + 1)'(ghsp_pkg::POOL_SIZE));
    assign h_gen     = handle_reg[ghsp_pkg::INDEX_BITS +: ghsp_pkg::GEN_BITS];
    assign malformed = h_neg || !idx_ok || (h_gen == '0);
    assign live      = in_use[handle_reg[ghsp_pkg::INDEX_BITS-1:0]]
                       && (entry_old.gen == h_gen);

    // Past the maximum the generation wraps to one, never to zero.
    assign gen_sum    = {1'b0, entry_old.gen} + 1'b1;
    assign gen_bumped = (gen_sum > ghsp_pkg::GENERATION_MAX)
                        ? ghsp_pkg::GEN_BITS'(1) : gen_sum[ghsp_pkg::GEN_BITS-1:0];

    always_comb
    begin
        status_calc   = ghsp_pkg::ST_OK;
        hout_calc     = '0;
        entry_new     = entry_old;
        wr_en         = 1'b0;
        map_upd.set   = 1'b0;
        map_upd.clr   = 1'b0;
        map_upd.idx   = idx_reg;
        unique case (cmd_reg)
            ghsp_pkg::CMD_ALLOC:
            begin
                if (full_reg)
                begin
                    status_calc = ghsp_pkg::ST_FULL;
                    hout_calc   = '1;
                end
                else
                begin
                    entry_new.gen  = gen_bumped;
                    entry_new.pins = '0;
                    wr_en          = go;
                    map_upd.set    = go;
                    hout_calc      = {1'b0, gen_bumped, idx_reg};
                end
            end
            ghsp_pkg::CMD_PIN:
            begin
                if (malformed)
                begin
                    status_calc = ghsp_pkg::ST_MALFORMED;
                end
                else if (!live)
                begin
                    status_calc = ghsp_pkg::ST_STALE;
                end
                else if (entry_old.pins == '1)
                begin
                    status_calc = ghsp_pkg::ST_BUSY;
                end
                else
                begin
                    entry_new.pins = entry_old.pins + 1'b1;
                    wr_en          = go;
                end
            end
            ghsp_pkg::CMD_UNPIN:
            begin
                if (h_neg || !idx_ok)
                begin
                    status_calc = ghsp_pkg::ST_MALFORMED;
                end
                else if (entry_old.pins != '0)
                begin
                    entry_new.pins = entry_old.pins - 1'b1;
                    wr_en          = go;
                end
            end
            ghsp_pkg::CMD_FREE:
            begin
                if (malformed)
                begin
                    status_calc = ghsp_pkg::ST_MALFORMED;
                end
                else if (!live)
                begin
                    status_calc = ghsp_pkg::ST_STALE;
                end
                else if (entry_old.pins != '0)
                begin
                    status_calc = ghsp_pkg::ST_BUSY;
                end
                else if (!empty_reg)
                begin
                    status_calc = ghsp_pkg::ST_WAITERS;
                end
                else
                begin
                    map_upd.clr = go;
                end
            end
            default:
            begin
                status_calc = ghsp_pkg::ST_OK;
            end
        endcase
    end

    // ----------------------------------------------------------- result side
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg     <= status_calc;
            handle_out_reg <= hout_calc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;

    // -------------------------------------------------------------- checks
    `GHSP_ASSERT_NEXT(a_accept_to_rmw, clk, rst_n, in_accept, state_reg == ghsp_pkg::S_RMW)
    `GHSP_ASSERT_NEXT(a_rmw_gives_result, clk, rst_n, go, out_valid)
    `GHSP_ASSERT_SAME(a_full_handle, clk, rst_n, out_valid && status == ghsp_pkg::ST_FULL, handle_out == 32'hffff_ffff)
    `GHSP_ASSERT_SAME(a_write_only_in_rmw, clk, rst_n, wr_en || map_upd.set || map_upd.clr, go)

endmodule
